[hw/rtl/cobs_frame_encoder_core_defines.svh]
`ifndef COBS_FRAME_ENCODER_CORE_DEFINES_SVH
`define COBS_FRAME_ENCODER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising edge, held off during reset.
`define COBS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cobs encoder check failed");

// Next-cycle implication.
`define COBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cobs encoder check failed");

`endif

[hw/rtl/cobs_enc_pkg.sv]
package cobs_enc_pkg;

    localparam int GROUP_MAX = 254;
    localparam int CODE_FULL = 255;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [63:0] out_bytes;
        logic [3:0]  out_count;
        logic        out_last;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CODE,
        ST_READ,
        ST_DATA,
        ST_DELIM
    } enc_state_t;

    typedef struct packed {
        logic       push;
        logic       delim;
        logic [7:0] data;
    } pack_req_t;

endpackage

[hw/rtl/cobs_enc_ram.sv]
module cobs_enc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 254,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/cobs_enc_pack.sv]
module cobs_enc_pack import cobs_enc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  pack_req_t req,
    output logic      ok,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic [55:0] pack_bytes_reg, pack_bytes_next;
    logic [2:0]  pack_count_reg, pack_count_next;
    logic        m_valid_reg, m_valid_next;
    out_item_t   m_data_reg, m_data_next;
    logic        out_free;
    logic        load;
    logic [55:0] bytes_ins;

    assign out_free = !m_valid_reg || m_ready;
    assign ok = req.delim ? out_free : ((pack_count_reg != 3'd7) || out_free);

    always_comb begin
        bytes_ins = pack_bytes_reg;
        for (int l = 0; l < 7; l++) begin
            if (pack_count_reg == 3'(l)) begin
                bytes_ins[8*l +: 8] = req.data;
            end
        end
    end

    always_comb begin
        pack_bytes_next = pack_bytes_reg;
        pack_count_next = pack_count_reg;
        m_data_next     = m_data_reg;
        load            = 1'b0;
        if (req.delim && ok) begin
            load                  = 1'b1;
            m_data_next.out_bytes = {8'h00, pack_bytes_reg};
            m_data_next.out_count = {1'b0, pack_count_reg} + 4'd1;
            m_data_next.out_last  = 1'b1;
            pack_bytes_next       = '0;
            pack_count_next       = '0;
        end else if (req.push && ok) begin
            if (pack_count_reg == 3'd7) begin
                load                  = 1'b1;
                m_data_next.out_bytes = {req.data, pack_bytes_reg};
                m_data_next.out_count = 4'd8;
                m_data_next.out_last  = 1'b0;
                pack_bytes_next       = '0;
                pack_count_next       = '0;
            end else begin
                pack_bytes_next = bytes_ins;
                pack_count_next = pack_count_reg + 3'd1;
            end
        end
        m_valid_next = load ? 1'b1 : (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pack_bytes_reg <= '0;
            pack_count_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            pack_bytes_reg <= pack_bytes_next;
            pack_count_reg <= pack_count_next;
            m_valid_reg    <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[hw/rtl/cobs_enc_ctrl.sv]
module cobs_enc_ctrl import cobs_enc_pkg::*; #(
    parameter int GROUP_DEPTH = GROUP_MAX,
    localparam int AW = (GROUP_DEPTH > 1) ? $clog2(GROUP_DEPTH) : 1,
    localparam int CW = $clog2(GROUP_DEPTH + 1)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  in_item_t      s_data,
    output logic          ram_we,
    output logic [AW-1:0] ram_waddr,
    output logic [7:0]    ram_wdata,
    output logic          ram_re,
    output logic [AW-1:0] ram_raddr,
    input  logic [7:0]    ram_rdata,
    output pack_req_t     pk_req,
    input  logic          pk_ok
);

    enc_state_t    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          last_reg, last_next;
    logic          again_reg, again_next;
    logic          accept;
    logic          in_zero;
    logic          full;
    logic          close_done;

    assign accept     = s_valid && (state_reg == ST_IDLE);
    assign in_zero    = (s_data.in_byte == 8'h00);
    assign full       = (count_reg == CW'(GROUP_DEPTH - 1));
    assign close_done = pk_ok && (((state_reg == ST_CODE) && (count_reg == '0)) ||
                        ((state_reg == ST_DATA) && (idx_reg + CW'(1) == count_reg)));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && (in_zero || full || s_data.in_last)) begin
                    state_next = ST_CODE;
                end
            end
            ST_CODE, ST_DATA: begin
                if (close_done) begin
                    if (last_reg && again_reg) begin
                        state_next = ST_CODE;
                    end else if (last_reg) begin
                        state_next = ST_DELIM;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end else if (pk_ok) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_DATA;
            end
            ST_DELIM: begin
                if (pk_ok) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready   = (state_reg == ST_IDLE);
        ram_we    = accept && !in_zero;
        ram_waddr = count_reg[AW-1:0];
        ram_wdata = s_data.in_byte;
        ram_re    = (state_reg == ST_READ);
        ram_raddr = idx_reg[AW-1:0];
        pk_req    = '0;
        case (state_reg)
            ST_CODE: begin
                pk_req.push = 1'b1;
                pk_req.data = 8'(count_reg) + 8'd1;
            end
            ST_DATA: begin
                pk_req.push = 1'b1;
                pk_req.data = ram_rdata;
            end
            ST_DELIM: begin
                pk_req.delim = 1'b1;
            end
            default: pk_req = '0;
        endcase
    end

    always_comb begin
        count_next = count_reg;
        idx_next   = idx_reg;
        last_next  = last_reg;
        again_next = again_reg;
        if (accept) begin
            last_next = s_data.in_last;
            if (in_zero || full) begin
                again_next = s_data.in_last;
            end else begin
                again_next = 1'b0;
            end
            if (!in_zero) begin
                count_next = count_reg + CW'(1);
            end
        end
        if ((state_reg == ST_CODE) && pk_ok) begin
            idx_next = '0;
        end
        if ((state_reg == ST_DATA) && pk_ok) begin
            idx_next = idx_reg + CW'(1);
        end
        if (close_done) begin
            count_next = '0;
            if (last_reg && again_reg) begin
                again_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            last_reg  <= 1'b0;
            again_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            last_reg  <= last_next;
            again_reg <= again_next;
        end
    end

endmodule

[hw/rtl/cobs_frame_encoder_core.sv]
// Channel  | Ports                        | Moves
// ---------+------------------------------+--------------------------------------
// input    | s_valid, s_ready, s_data     | one raw byte plus end-of-frame flag
// result   | m_valid, m_ready, m_data     | up to eight encoded bytes per word
//
// A non-zero byte that leaves its group open is a single store write.
// A byte that closes a group of n held bytes is accepted, then its code byte is
// sent, then one read and one pack step follow per byte through the store port.
// End of frame adds the delimiter, plus the empty 0x01 group after a full run or
// a trailing zero. Reset is synchronous, active low.
// A full result register that is not taken stalls the packer and thus the input.
`include "cobs_frame_encoder_core_defines.svh"

module cobs_frame_encoder_core import cobs_enc_pkg::*; #(
    parameter int GROUP_DEPTH = GROUP_MAX
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int AW = (GROUP_DEPTH > 1) ? $clog2(GROUP_DEPTH) : 1;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;
    pack_req_t     pk_req;
    logic          pk_ok;
    logic          s_zero_fire;
    logic          m_full_word;
    logic          m_count_ok;

    cobs_enc_ctrl #(
        .GROUP_DEPTH(GROUP_DEPTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .pk_req    (pk_req),
        .pk_ok     (pk_ok)
    );

    cobs_enc_ram #(
        .WIDTH(8),
        .DEPTH(GROUP_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    cobs_enc_pack u_pack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (pk_req),
        .ok      (pk_ok),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    assign s_zero_fire = s_valid && s_ready && (s_data.in_byte == 8'h00);
    assign m_full_word = (m_data.out_count == 4'd8);
    assign m_count_ok  = (m_data.out_count != 4'd0) && (m_data.out_count <= 4'd8);

    `COBS_ASSERT_NEXT(a_zero_closes, aclk, aresetn, s_zero_fire, !s_ready)
    `COBS_ASSERT_NEXT(a_delim_word, aclk, aresetn, pk_req.delim && pk_ok, m_valid && m_data.out_last)
    `COBS_ASSERT_NOW(a_mid_word_full, aclk, aresetn, m_valid && !m_data.out_last, m_full_word)
    `COBS_ASSERT_NOW(a_count_range, aclk, aresetn, m_valid, m_count_ok)

endmodule
